### rtl/preemptive_shortest_job_scheduler_core_assert.svh
// assertion macros used by the scheduler core
`ifndef PREEMPTIVE_SHORTEST_JOB_SCHEDULER_CORE_ASSERT_SVH
`define PREEMPTIVE_SHORTEST_JOB_SCHEDULER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PSJS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// next-cycle implication, checked out of reset
`define PSJS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

### rtl/psjs_pkg.sv
`timescale 1ns / 1ps
package psjs_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int SLOT_BITS   = $clog2(QUEUE_DEPTH);
  localparam int TIME_BITS   = 32;
  localparam int ID_BITS     = 16;
  localparam int CT_BITS     = 33;

  localparam logic OP_ARRIVAL  = 1'b0;
  localparam logic OP_COMPLETE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ARR,
    ST_ELAPSED,
    ST_CUT,
    ST_DONE,
    ST_SCAN,
    ST_SCAN_END,
    ST_PICK
  } state_t;

  // result of the shared subtract unit
  typedef struct packed {
    logic [TIME_BITS-1:0] diff;
    logic [TIME_BITS-1:0] sat;
    logic                 lt;
    logic                 eq;
  } sub_res_t;

  typedef struct packed {
    logic [ID_BITS-1:0]   id;
    logic [TIME_BITS-1:0] size;
    logic [TIME_BITS-1:0] rem;
  } entry_t;

  typedef struct packed {
    logic                 cancel_pending;
    logic                 schedule_valid;
    logic [CT_BITS-1:0]   completion_time;
    logic                 done_valid;
    logic [ID_BITS-1:0]   done_job_id;
    logic                 running_valid;
    logic [ID_BITS-1:0]   running_job_id;
    logic                 dropped;
  } result_t;

endpackage

### rtl/psjs_sub.sv
`timescale 1ns / 1ps
module psjs_sub (
  input  logic [psjs_pkg::TIME_BITS-1:0] a,
  input  logic [psjs_pkg::TIME_BITS-1:0] b,
  output psjs_pkg::sub_res_t             res
);
  import psjs_pkg::*;

  logic [TIME_BITS:0] wide;

  // one subtractor serves compare, elapsed time and saturating decrement
  always_comb begin
    wide     = {1'b0, a} - {1'b0, b};
    res.diff = wide[TIME_BITS-1:0];
    res.lt   = wide[TIME_BITS];
    res.eq   = (wide[TIME_BITS-1:0] == '0);
    res.sat  = wide[TIME_BITS] ? '0 : wide[TIME_BITS-1:0];
  end

endmodule

### rtl/preemptive_shortest_job_scheduler_core.sv
`timescale 1ns / 1ps
// Preemptive shortest-job-first scheduler. Pulse start while busy is low to
// hand in one event word (arrival or completion); busy stays high until the
// result word has been formed, and the result then shows on the out_ ports for
// exactly one cycle with out_valid high. The receiver cannot stall, so it must
// take every word in the cycle it appears; the result registers hold their
// value only until the next event word is accepted. An arrival that preempts
// the running job goes on through elapsed time, then the cut of the old job's
// remaining time, both through the one shared subtractor. A completion with
// nothing running ends in ST_DONE; otherwise the job table sits in a memory
// with one write port and a registered read, and the next job is found by
// reading one slot per cycle and comparing it against the best so far in the
// same subtractor. Completion times are now plus remaining, 33 bits wide.
`include "preemptive_shortest_job_scheduler_core_assert.svh"
module preemptive_shortest_job_scheduler_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_operation,
  input  logic [psjs_pkg::ID_BITS-1:0]     in_job_id,
  input  logic [psjs_pkg::TIME_BITS-1:0]   in_job_size,
  input  logic [psjs_pkg::TIME_BITS-1:0]   in_job_remaining,
  input  logic [psjs_pkg::TIME_BITS-1:0]   in_now,
  output logic                             out_valid,
  output logic                             out_cancel_pending,
  output logic                             out_schedule_valid,
  output logic [psjs_pkg::CT_BITS-1:0]     out_completion_time,
  output logic                             out_done_valid,
  output logic [psjs_pkg::ID_BITS-1:0]     out_done_job_id,
  output logic                             out_running_valid,
  output logic [psjs_pkg::ID_BITS-1:0]     out_running_job_id,
  output logic                             out_dropped
);
  import psjs_pkg::*;

  // sequencer state
  state_t state_r, state_nxt;

  // per-slot occupancy, cleared at reset
  logic [QUEUE_DEPTH-1:0] valid_r, valid_nxt;

  // running job and a cached copy of its table entry
  logic                 run_present_r, run_present_nxt;
  logic [SLOT_BITS-1:0] run_slot_r, run_slot_nxt;
  logic [ID_BITS-1:0]   run_id_r, run_id_nxt;
  logic [TIME_BITS-1:0] run_size_r, run_size_nxt;
  logic [TIME_BITS-1:0] run_rem_r, run_rem_nxt;
  logic [TIME_BITS-1:0] start_time_r, start_time_nxt;

  // captured event word
  logic [ID_BITS-1:0]   id_r, id_nxt;
  logic [TIME_BITS-1:0] size_r, size_nxt;
  logic [TIME_BITS-1:0] rem_r, rem_nxt;
  logic [TIME_BITS-1:0] now_r, now_nxt;

  logic [TIME_BITS-1:0] elapsed_r, elapsed_nxt;

  // scan of the table for the next job
  logic [SLOT_BITS-1:0] scan_idx_r, scan_idx_nxt;
  logic                 chk_vld_r, chk_vld_nxt;
  logic [SLOT_BITS-1:0] chk_slot_r, chk_slot_nxt;
  logic                 best_found_r, best_found_nxt;
  logic [SLOT_BITS-1:0] best_slot_r, best_slot_nxt;
  logic [ID_BITS-1:0]   best_id_r, best_id_nxt;
  logic [TIME_BITS-1:0] best_size_r, best_size_nxt;
  logic [TIME_BITS-1:0] best_rem_r, best_rem_nxt;

  // result word
  result_t res_r, res_nxt;
  logic    out_valid_r, out_valid_nxt;

  // job table memory
  entry_t               mem [QUEUE_DEPTH];
  logic                 wr_en;
  logic [SLOT_BITS-1:0] wr_addr;
  entry_t               wr_data;
  logic [SLOT_BITS-1:0] rd_addr;
  entry_t               rd_data_r;

  // shared subtract unit
  logic [TIME_BITS-1:0] alu_a, alu_b;
  sub_res_t             alu_res;

  // lowest free slot
  logic                 free_found;
  logic [SLOT_BITS-1:0] free_slot;

  logic [TIME_BITS-1:0] ct_addend;
  logic [CT_BITS-1:0]   ct_sum;
  logic                 finish;
  logic                 better;

  psjs_sub u_sub (
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // priority encoder, lowest index wins
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_slot  = SLOT_BITS'(i);
      end
    end
  end

  // scanned slot orders before the best so far (later slot never wins a full tie)
  assign better = valid_r[chk_slot_r] &&
                  (!best_found_r || alu_res.lt ||
                   (alu_res.eq && (rd_data_r.id < best_id_r)));

  assign ct_sum = {1'b0, now_r} + {1'b0, ct_addend};

  always_comb begin
    state_nxt       = state_r;
    valid_nxt       = valid_r;
    run_present_nxt = run_present_r;
    run_slot_nxt    = run_slot_r;
    run_id_nxt      = run_id_r;
    run_size_nxt    = run_size_r;
    run_rem_nxt     = run_rem_r;
    start_time_nxt  = start_time_r;
    id_nxt          = id_r;
    size_nxt        = size_r;
    rem_nxt         = rem_r;
    now_nxt         = now_r;
    elapsed_nxt     = elapsed_r;
    scan_idx_nxt    = scan_idx_r;
    chk_vld_nxt     = chk_vld_r;
    chk_slot_nxt    = chk_slot_r;
    best_found_nxt  = best_found_r;
    best_slot_nxt   = best_slot_r;
    best_id_nxt     = best_id_r;
    best_size_nxt   = best_size_r;
    best_rem_nxt    = best_rem_r;
    res_nxt         = res_r;
    out_valid_nxt   = 1'b0;
    wr_en           = 1'b0;
    wr_addr         = free_slot;
    wr_data         = '{id: id_r, size: size_r, rem: rem_r};
    rd_addr         = scan_idx_r;
    alu_a           = rd_data_r.size;
    alu_b           = best_size_r;
    ct_addend       = rem_r;
    finish          = 1'b0;

    unique case (state_r) inside
      ST_IDLE: begin
        if (start) begin
          id_nxt    = in_job_id;
          size_nxt  = in_job_size;
          rem_nxt   = in_job_remaining;
          now_nxt   = in_now;
          res_nxt   = '0;
          state_nxt = (in_operation == OP_ARRIVAL) ? ST_ARR : ST_DONE;
        end
      end

      ST_ARR: begin
        alu_a = size_r;
        alu_b = run_size_r;
        if (!free_found) begin
          res_nxt.dropped = 1'b1;
          finish          = 1'b1;
        end else begin
          wr_en                = 1'b1;
          valid_nxt[free_slot] = 1'b1;
          if (!run_present_r) begin
            run_present_nxt        = 1'b1;
            run_slot_nxt           = free_slot;
            run_id_nxt             = id_r;
            run_size_nxt           = size_r;
            run_rem_nxt            = rem_r;
            start_time_nxt         = now_r;
            res_nxt.schedule_valid = 1'b1;
            res_nxt.completion_time = ct_sum;
            finish                 = 1'b1;
          end else if (alu_res.lt) begin
            // remember the new slot while the old job is charged
            best_slot_nxt = free_slot;
            state_nxt     = ST_ELAPSED;
          end else begin
            finish = 1'b1;
          end
        end
      end

      ST_ELAPSED: begin
        // time going backwards counts as nothing
        alu_a       = now_r;
        alu_b       = start_time_r;
        elapsed_nxt = alu_res.sat;
        state_nxt   = ST_CUT;
      end

      ST_CUT: begin
        alu_a   = run_rem_r;
        alu_b   = elapsed_r;
        wr_en   = 1'b1;
        wr_addr = run_slot_r;
        wr_data = '{id: run_id_r, size: run_size_r, rem: alu_res.sat};
        run_slot_nxt            = best_slot_r;
        run_id_nxt              = id_r;
        run_size_nxt            = size_r;
        run_rem_nxt             = rem_r;
        start_time_nxt          = now_r;
        res_nxt.cancel_pending  = 1'b1;
        res_nxt.schedule_valid  = 1'b1;
        res_nxt.completion_time = ct_sum;
        finish                  = 1'b1;
      end

      ST_DONE: begin
        start_time_nxt = now_r;
        if (!run_present_r) begin
          finish = 1'b1;
        end else begin
          res_nxt.done_valid    = 1'b1;
          res_nxt.done_job_id   = run_id_r;
          valid_nxt[run_slot_r] = 1'b0;
          run_present_nxt       = 1'b0;
          scan_idx_nxt          = '0;
          chk_vld_nxt           = 1'b0;
          best_found_nxt        = 1'b0;
          state_nxt             = ST_SCAN;
        end
      end

      ST_SCAN, ST_SCAN_END: begin
        if (chk_vld_r && better) begin
          best_found_nxt = 1'b1;
          best_slot_nxt  = chk_slot_r;
          best_id_nxt    = rd_data_r.id;
          best_size_nxt  = rd_data_r.size;
          best_rem_nxt   = rd_data_r.rem;
        end
        if (state_r == ST_SCAN) begin
          chk_vld_nxt  = 1'b1;
          chk_slot_nxt = scan_idx_r;
          scan_idx_nxt = scan_idx_r + 1'b1;
          if (scan_idx_r == SLOT_BITS'(QUEUE_DEPTH - 1)) begin
            state_nxt = ST_SCAN_END;
          end
        end else begin
          chk_vld_nxt = 1'b0;
          state_nxt   = ST_PICK;
        end
      end

      ST_PICK: begin
        ct_addend = best_rem_r;
        if (best_found_r) begin
          run_present_nxt         = 1'b1;
          run_slot_nxt            = best_slot_r;
          run_id_nxt              = best_id_r;
          run_size_nxt            = best_size_r;
          run_rem_nxt             = best_rem_r;
          res_nxt.schedule_valid  = 1'b1;
          res_nxt.completion_time = ct_sum;
        end
        finish = 1'b1;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // running_* reflect the state after the event
    if (finish) begin
      res_nxt.running_valid  = run_present_nxt;
      res_nxt.running_job_id = run_present_nxt ? run_id_nxt : '0;
      out_valid_nxt          = 1'b1;
      state_nxt              = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      valid_r       <= '0;
      run_present_r <= 1'b0;
      run_slot_r    <= '0;
      start_time_r  <= '0;
      chk_vld_r     <= 1'b0;
      best_found_r  <= 1'b0;
      scan_idx_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      valid_r       <= valid_nxt;
      run_present_r <= run_present_nxt;
      run_slot_r    <= run_slot_nxt;
      start_time_r  <= start_time_nxt;
      chk_vld_r     <= chk_vld_nxt;
      best_found_r  <= best_found_nxt;
      scan_idx_r    <= scan_idx_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    run_id_r    <= run_id_nxt;
    run_size_r  <= run_size_nxt;
    run_rem_r   <= run_rem_nxt;
    id_r        <= id_nxt;
    size_r      <= size_nxt;
    rem_r       <= rem_nxt;
    now_r       <= now_nxt;
    elapsed_r   <= elapsed_nxt;
    chk_slot_r  <= chk_slot_nxt;
    best_slot_r <= best_slot_nxt;
    best_id_r   <= best_id_nxt;
    best_size_r <= best_size_nxt;
    best_rem_r  <= best_rem_nxt;
    res_r       <= res_nxt;
  end

  assign busy                = (state_r != ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_cancel_pending  = res_r.cancel_pending;
  assign out_schedule_valid  = res_r.schedule_valid;
  assign out_completion_time = res_r.completion_time;
  assign out_done_valid      = res_r.done_valid;
  assign out_done_job_id     = res_r.done_job_id;
  assign out_running_valid   = res_r.running_valid;
  assign out_running_job_id  = res_r.running_job_id;
  assign out_dropped         = res_r.dropped;

  // the running job always owns an occupied slot between events
  `PSJS_ASSERT_NOW(a_run_slot_held, clk, rst_n,
    (state_r == ST_IDLE) && run_present_r, valid_r[run_slot_r])
  // a preemption always comes with a new completion time
  `PSJS_ASSERT_NOW(a_cancel_has_sched, clk, rst_n,
    out_valid_r && res_r.cancel_pending, res_r.schedule_valid && res_r.running_valid)
  // a dropped arrival never reports a completion or a new schedule
  `PSJS_ASSERT_NOW(a_drop_quiet, clk, rst_n,
    out_valid_r && res_r.dropped, !res_r.done_valid && !res_r.schedule_valid)
  // an accepted event keeps the block busy in the next cycle
  `PSJS_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy && !out_valid_r)

endmodule

### verif/tb_preemptive_shortest_job_scheduler_core.sv
`timescale 1ns / 1ps
module tb_preemptive_shortest_job_scheduler_core;
  import psjs_pkg::*;

  // run limit in clock cycles, far above the slowest legal run
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_WORDS = 650;
  localparam int TAIL_CYCLES  = 40;

  // one scheduling event plus how the driver should present it
  typedef struct {
    logic                 op;
    logic [ID_BITS-1:0]   id;
    logic [TIME_BITS-1:0] size;
    logic [TIME_BITS-1:0] rem;
    logic [TIME_BITS-1:0] now;
    int                   idle_pct;  // chance per cycle that the sender holds off
    bit                   drain;     // hold this word until every outcome is back
  } sched_event_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 in_operation = OP_ARRIVAL;
  logic [ID_BITS-1:0]   in_job_id = '0;
  logic [TIME_BITS-1:0] in_job_size = '0;
  logic [TIME_BITS-1:0] in_job_remaining = '0;
  logic [TIME_BITS-1:0] in_now = '0;
  logic                 out_valid;
  logic                 out_cancel_pending;
  logic                 out_schedule_valid;
  logic [CT_BITS-1:0]   out_completion_time;
  logic                 out_done_valid;
  logic [ID_BITS-1:0]   out_done_job_id;
  logic                 out_running_valid;
  logic [ID_BITS-1:0]   out_running_job_id;
  logic                 out_dropped;

  sched_event_t pending_events[$];
  sched_event_t offered_event;
  result_t      awaited_outcomes[$];
  result_t      seen_outcome;
  result_t      want_outcome;
  int           mismatches = 0;
  int           cycle_count = 0;

  // shadow job table kept by the testbench
  bit                   slot_used [QUEUE_DEPTH];
  logic [ID_BITS-1:0]   slot_id   [QUEUE_DEPTH];
  logic [TIME_BITS-1:0] slot_size [QUEUE_DEPTH];
  logic [TIME_BITS-1:0] slot_rem  [QUEUE_DEPTH];
  int                   run_slot = 0;
  bit                   run_on = 1'b0;
  logic [TIME_BITS-1:0] run_since = '0;

  always #6 clk = ~clk;

  preemptive_shortest_job_scheduler_core u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_operation        (in_operation),
    .in_job_id           (in_job_id),
    .in_job_size         (in_job_size),
    .in_job_remaining    (in_job_remaining),
    .in_now              (in_now),
    .out_valid           (out_valid),
    .out_cancel_pending  (out_cancel_pending),
    .out_schedule_valid  (out_schedule_valid),
    .out_completion_time (out_completion_time),
    .out_done_valid      (out_done_valid),
    .out_done_job_id     (out_done_job_id),
    .out_running_valid   (out_running_valid),
    .out_running_job_id  (out_running_job_id),
    .out_dropped         (out_dropped)
  );

  // applies one event to the shadow table and returns the outcome word it gives
  function automatic result_t scheduler_outcome(sched_event_t ev);
    result_t              r;
    int                   free_slot;
    int                   best;
    logic [TIME_BITS-1:0] elapsed;
    logic [TIME_BITS-1:0] left;
    r = '0;
    if (ev.op == OP_ARRIVAL) begin
      free_slot = -1;
      for (int i = 0; i < QUEUE_DEPTH; i++)
        if (!slot_used[i] && free_slot < 0) free_slot = i;
      if (free_slot < 0) begin
        // full table: job is thrown away, nothing else moves
        r.dropped = 1'b1;
      end else begin
        slot_used[free_slot] = 1'b1;
        slot_id[free_slot]   = ev.id;
        slot_size[free_slot] = ev.size;
        slot_rem[free_slot]  = ev.rem;
        // strictly shorter jobs preempt, equal sizes wait their turn
        if (!run_on || ev.size < slot_size[run_slot]) begin
          if (run_on) begin
            // time running backwards counts as no progress
            elapsed = (ev.now >= run_since) ? ev.now - run_since : '0;
            left = slot_rem[run_slot];
            slot_rem[run_slot] = (left > elapsed) ? left - elapsed : '0;
            r.cancel_pending = 1'b1;
          end
          r.schedule_valid  = 1'b1;
          r.completion_time = {1'b0, ev.now} + {1'b0, ev.rem};
          run_slot  = free_slot;
          run_on    = 1'b1;
          run_since = ev.now;
        end
      end
    end else begin
      run_since = ev.now;
      if (run_on) begin
        r.done_valid  = 1'b1;
        r.done_job_id = slot_id[run_slot];
        slot_used[run_slot] = 1'b0;
        run_on = 1'b0;
        // pick shortest, then lowest id; ascending scan keeps the lower slot on a full tie
        best = -1;
        for (int i = 0; i < QUEUE_DEPTH; i++)
          if (slot_used[i] && (best < 0 || slot_size[i] < slot_size[best] ||
              (slot_size[i] == slot_size[best] && slot_id[i] < slot_id[best])))
            best = i;
        if (best >= 0) begin
          r.schedule_valid  = 1'b1;
          r.completion_time = {1'b0, ev.now} + {1'b0, slot_rem[best]};
          run_slot = best;
          run_on   = 1'b1;
        end
      end
    end
    r.running_valid  = run_on;
    r.running_job_id = run_on ? slot_id[run_slot] : '0;
    return r;
  endfunction

  task automatic queue_event(logic op, logic [ID_BITS-1:0] id, logic [TIME_BITS-1:0] size,
                             logic [TIME_BITS-1:0] rem, logic [TIME_BITS-1:0] now,
                             int idle_pct, bit drain);
    sched_event_t ev;
    ev.op = op;
    ev.id = id;
    ev.size = size;
    ev.rem = rem;
    ev.now = now;
    ev.idle_pct = idle_pct;
    ev.drain = drain;
    pending_events.push_back(ev);
  endtask

  task automatic check_field(string name, logic [CT_BITS-1:0] want, logic [CT_BITS-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // driver: a word is taken at an edge with start high and busy low
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) begin
        // accepted at this edge, so its outcome becomes due
        awaited_outcomes.push_back(scheduler_outcome(offered_event));
        void'(pending_events.pop_front());
      end
      // offer the next word unless the sender idles or a drain is pending
      if (pending_events.size() != 0 &&
          !(pending_events[0].drain && (awaited_outcomes.size() != 0 || busy)) &&
          $urandom_range(0, 99) >= pending_events[0].idle_pct) begin
        offered_event    = pending_events[0];
        start            <= 1'b1;
        in_operation     <= pending_events[0].op;
        in_job_id        <= pending_events[0].id;
        in_job_size      <= pending_events[0].size;
        in_job_remaining <= pending_events[0].rem;
        in_now           <= pending_events[0].now;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: every strobed word must match the oldest outstanding outcome
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      seen_outcome.cancel_pending  = out_cancel_pending;
      seen_outcome.schedule_valid  = out_schedule_valid;
      seen_outcome.completion_time = out_completion_time;
      seen_outcome.done_valid      = out_done_valid;
      seen_outcome.done_job_id     = out_done_job_id;
      seen_outcome.running_valid   = out_running_valid;
      seen_outcome.running_job_id  = out_running_job_id;
      seen_outcome.dropped         = out_dropped;
      if (awaited_outcomes.size() == 0) begin
        $display("%0t ns: unexpected result word, expected none, actual %p",
                 $time, seen_outcome);
        mismatches++;
      end else begin
        want_outcome = awaited_outcomes.pop_front();
        check_field("cancel_pending", CT_BITS'(want_outcome.cancel_pending),
                    CT_BITS'(seen_outcome.cancel_pending));
        check_field("schedule_valid", CT_BITS'(want_outcome.schedule_valid),
                    CT_BITS'(seen_outcome.schedule_valid));
        check_field("completion_time", want_outcome.completion_time,
                    seen_outcome.completion_time);
        check_field("done_valid", CT_BITS'(want_outcome.done_valid),
                    CT_BITS'(seen_outcome.done_valid));
        check_field("done_job_id", CT_BITS'(want_outcome.done_job_id),
                    CT_BITS'(seen_outcome.done_job_id));
        check_field("running_valid", CT_BITS'(want_outcome.running_valid),
                    CT_BITS'(seen_outcome.running_valid));
        check_field("running_job_id", CT_BITS'(want_outcome.running_job_id),
                    CT_BITS'(seen_outcome.running_job_id));
        check_field("dropped", CT_BITS'(want_outcome.dropped),
                    CT_BITS'(seen_outcome.dropped));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("preemptive_shortest_job_scheduler_core verification failed");
      $finish;
    end
  end

  initial begin
    logic [TIME_BITS-1:0] t;
    logic [ID_BITS-1:0]   id;
    logic [TIME_BITS-1:0] size;
    logic [TIME_BITS-1:0] rem;
    int                   made;
    int                   burst_len;
    int                   arrival_pct;
    int                   idle;
    bit                   drain_next;

    for (int i = 0; i < QUEUE_DEPTH; i++) slot_used[i] = 1'b0;

    // directed words
    // completion with nothing running
    queue_event(OP_COMPLETE, 16'hffff, '1, '1, 32'd5, 30, 1'b0);
    // first arrival starts at once, no cancel
    queue_event(OP_ARRIVAL, 16'h0000, 32'd100, 32'd50, 32'd10, 30, 1'b0);
    // equal size does not preempt
    queue_event(OP_ARRIVAL, 16'hffff, 32'd100, 32'd20, 32'd12, 30, 1'b0);
    // shorter job preempts, old job charged for elapsed time
    queue_event(OP_ARRIVAL, 16'd7, 32'd40, 32'd30, 32'd20, 30, 1'b0);
    queue_event(OP_ARRIVAL, 16'd3, 32'd40, 32'd9, 32'd8, 30, 1'b0);
    // preempt with time going backwards
    queue_event(OP_ARRIVAL, 16'd8, 32'd30, 32'd5, 32'd15, 30, 1'b0);
    // widest completion time, carry into bit 32
    queue_event(OP_ARRIVAL, 16'd9, 32'd0, '1, '1, 30, 1'b0);
    // same size and id as the runner, tie settled by slot
    queue_event(OP_ARRIVAL, 16'd9, 32'd0, 32'd1, 32'd0, 30, 1'b0);
    // fill the rest of the table
    for (int k = 0; k < 9; k++)
      queue_event(OP_ARRIVAL, ID_BITS'(20 + k), '1, (k == 0) ? 32'd0 : 32'd1000 * k,
                  32'd100 + k, 0, 1'b0);
    // full table drops the arrival
    queue_event(OP_ARRIVAL, 16'h5555, 32'd1, 32'd1, 32'd200, 0, 1'b0);
    // completions pick the ordered head
    queue_event(OP_COMPLETE, 16'h0, 32'h0, 32'h0, 32'd300, 0, 1'b0);
    queue_event(OP_COMPLETE, 16'haaaa, 32'haaaa_aaaa, 32'h5555_5555, 32'd310, 0, 1'b0);
    // sender holds off until the block has gone quiet
    queue_event(OP_ARRIVAL, 16'd40, 32'd5, 32'd77, 32'd320, 0, 1'b1);

    // random words in bursts that lean toward filling or draining the table
    t = 32'd400;
    made = 0;
    drain_next = 1'b0;
    while (made < RANDOM_WORDS) begin
      burst_len = $urandom_range(8, 40);
      case ($urandom_range(0, 2))
        0:       arrival_pct = 80;
        1:       arrival_pct = 50;
        default: arrival_pct = 25;
      endcase
      for (int b = 0; b < burst_len && made < RANDOM_WORDS; b++) begin
        // idle phases: none, heavy, light, none
        case ((made / 80) % 4)
          1:       idle = 67;
          2:       idle = 8;
          default: idle = 0;
        endcase
        case ($urandom_range(0, 99)) inside
          [0:6]:   t = t - $urandom_range(1, 200);
          [7:10]:  t = $urandom;
          default: t = t + $urandom_range(0, 60);
        endcase
        if ($urandom_range(0, 99) < arrival_pct) begin
          id = ($urandom_range(0, 9) < 6) ? ID_BITS'($urandom_range(0, 7))
                                          : ID_BITS'($urandom);
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: size = $urandom_range(0, 7);
            5, 6, 7:       size = $urandom_range(0, 1000);
            default:       size = $urandom;
          endcase
          case ($urandom_range(0, 4))
            0, 1:    rem = $urandom_range(0, 100);
            2, 3:    rem = $urandom_range(0, 1000000);
            default: rem = $urandom;
          endcase
          queue_event(OP_ARRIVAL, id, size, rem, t, idle, drain_next);
        end else begin
          // completion carries don't-care fields
          queue_event(OP_COMPLETE, ID_BITS'($urandom), $urandom, $urandom, t, idle,
                      drain_next);
        end
        drain_next = (made == RANDOM_WORDS / 2);
        made++;
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // wait for all words to go in and every outcome to come back
    while (pending_events.size() != 0 || start || awaited_outcomes.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && awaited_outcomes.size() == 0) begin
      $display("preemptive_shortest_job_scheduler_core verification clean");
    end else begin
      $display("preemptive_shortest_job_scheduler_core verification failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/psjs_pkg.sv
rtl/psjs_sub.sv
rtl/preemptive_shortest_job_scheduler_core.sv
verif/tb_preemptive_shortest_job_scheduler_core.sv
